>>> hdl/bdnms_pkg.sv
// Shared types, constants and state encoding for the box decode / NMS block.
package bdnms_pkg;

	localparam int MAX_CAND  = 1024;
	localparam int CAND_AW   = $clog2(MAX_CAND);
	localparam int CAND_CW   = CAND_AW + 1;
	localparam int MAX_KEEP  = 64;
	localparam int KEEP_AW   = $clog2(MAX_KEEP);
	localparam int KEEP_CW   = KEEP_AW + 1;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 20;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SCORE_THR = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OVL_THR   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_KEPT  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_LEFT  = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_TOP   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_IMG_W     = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_IMG_H     = 4'd7;

	typedef struct packed {
		logic [15:0] b;
		logic [15:0] r;
		logic [15:0] t;
		logic [15:0] l;
	} box_t;

	typedef struct packed {
		logic [15:0] score;
		logic [7:0]  cls;
		box_t        box;
	} cand_t;

	typedef struct packed {
		cand_t       c;
		logic [31:0] area;
	} kept_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MUL,
		ST_CLIP,
		ST_CHK,
		ST_FULL_RD,
		ST_FULL_CMP,
		ST_INS_RD,
		ST_INS_CMP,
		ST_NMS_INIT,
		ST_NMS_RD,
		ST_NMS_AREA,
		ST_K_RD,
		ST_K0,
		ST_K1,
		ST_K2,
		ST_K3,
		ST_E_RD,
		ST_E_LD,
		ST_E_EMPTY,
		ST_E_WAIT
	} state_t;

endpackage

>>> hdl/bdnms_if.sv
// Valid/ready channel interfaces: candidate input, result output, configuration writes.
interface bdnms_cand_if;
	logic        valid;
	logic        ready;
	logic [7:0]  class_index;
	logic [15:0] score;
	logic [15:0] ctr_x;
	logic [15:0] ctr_y;
	logic [15:0] box_width;
	logic [15:0] box_height;
	logic        last_candidate;
	modport source (output valid, class_index, score, ctr_x, ctr_y, box_width,
		box_height, last_candidate, input ready);
	modport sink (input valid, class_index, score, ctr_x, ctr_y, box_width,
		box_height, last_candidate, output ready);
endinterface

interface bdnms_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_class;
	logic [15:0] out_score;
	logic [15:0] left;
	logic [15:0] top;
	logic [15:0] right;
	logic [15:0] bottom;
	logic        box_valid;
	logic        last_box;
	modport source (output valid, out_class, out_score, left, top, right, bottom,
		box_valid, last_box, input ready);
	modport sink (input valid, out_class, out_score, left, top, right, bottom,
		box_valid, last_box, output ready);
endinterface

interface bdnms_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [19:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/box_decode_greedy_nms_top.sv
// Box decode with sorted candidate store and greedy same-class NMS, top level.
//
// One candidate is taken at a time. Decoding uses one shared 18x20
// multiplier, with a multiply step and a clip step per edge. Insertion
// into the sorted store (1024 x 88 bit single-read memory) reads and
// rewrites each entry that it moves. On the last candidate the suppression
// pass reads the stored entries in order until the kept limit is reached
// and compares each against the kept boxes of the same class (64 x 120 bit
// memory), then emits the kept boxes, subject to output back-pressure. The
// result register lets the next frame start only after the final result
// has been taken. No clearing pass is needed after reset.
module box_decode_greedy_nms_top import bdnms_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	bdnms_cand_if.sink    cand,
	bdnms_res_if.source   res,
	bdnms_cfg_if.sink     cfg
);

	// configuration registers
	logic [15:0] score_thr_q, ovl_thr_q;
	logic [6:0]  max_kept_q;
	logic [11:0] pad_left_q, pad_top_q, img_w_q, img_h_q;
	logic [19:0] inv_scale_q;

	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_thr_q <= '0;
			ovl_thr_q   <= 16'd29491;
			max_kept_q  <= 7'd64;
			pad_left_q  <= '0;
			pad_top_q   <= '0;
			inv_scale_q <= 20'd65536;
			img_w_q     <= 12'd640;
			img_h_q     <= 12'd640;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SCORE_THR: score_thr_q <= cfg.data[15:0];
				REG_OVL_THR:   ovl_thr_q   <= cfg.data[15:0];
				REG_MAX_KEPT:  max_kept_q  <= cfg.data[6:0];
				REG_PAD_LEFT:  pad_left_q  <= cfg.data[11:0];
				REG_PAD_TOP:   pad_top_q   <= cfg.data[11:0];
				REG_INV_SCALE: inv_scale_q <= cfg.data;
				REG_IMG_W:     img_w_q     <= cfg.data[11:0];
				REG_IMG_H:     img_h_q     <= cfg.data[11:0];
				default: ;
			endcase
		end
	end

	// state
	state_t state_q, state_d;

	// control registers
	logic [CAND_CW-1:0] count_q;
	logic [CAND_CW-1:0] ins_i_q;
	logic [CAND_CW-1:0] nms_i_q;
	logic [KEEP_CW-1:0] kcnt_q;
	logic [KEEP_CW-1:0] kj_q;
	logic [1:0]         edge_q;
	logic               out_valid_q;

	// candidate payload
	logic [7:0]  cls_q;
	logic [15:0] score_q, cx_q, cy_q, w_q, h_q;
	logic        last_q;
	logic [15:0] edges_q [4];
	logic [37:0] prod_s1;
	logic        pos_s1;

	// suppression datapath
	cand_t       cur_q;
	logic [31:0] area_q;
	logic [15:0] iw_s1, ih_s1;
	logic [31:0] karea_s1;
	logic [31:0] inter_s2, inter_s3;
	logic [32:0] uni_s2, uni_s3;
	logic [48:0] prod_s3;

	// output register
	kept_t out_q;
	logic  out_bv_q, out_last_q;

	// memories
	cand_t store_mem [MAX_CAND];
	kept_t keep_mem  [MAX_KEEP];
	cand_t store_rd_q;
	kept_t keep_rd_q;

	logic               st_re, st_we, kp_re, kp_we;
	logic [CAND_AW-1:0] st_raddr, st_waddr;
	logic [KEEP_AW-1:0] kp_raddr;
	cand_t              st_wdata;

	// helpers
	logic [6:0]  limit;
	box_t        new_box;
	cand_t       new_cand;
	logic        degenerate, full, nms_more, kj_done, cls_match, beaten;
	logic        suppress, out_take;

	always_comb begin
		if (max_kept_q == 7'd0)
			limit = 7'd1;
		else if (max_kept_q > 7'(MAX_KEEP))
			limit = 7'(MAX_KEEP);
		else
			limit = max_kept_q;
	end

	assign new_box    = '{b: edges_q[3], r: edges_q[2], t: edges_q[1], l: edges_q[0]};
	assign new_cand   = '{score: score_q, cls: cls_q, box: new_box};
	assign degenerate = !(new_box.r > new_box.l && new_box.b > new_box.t);
	assign full       = (count_q == CAND_CW'(MAX_CAND));
	assign nms_more   = (nms_i_q < count_q) && (KEEP_CW'(limit) > kcnt_q);
	assign kj_done    = (kj_q == kcnt_q);
	assign cls_match  = (keep_rd_q.c.cls == cur_q.cls);
	assign beaten     = (store_rd_q.score < score_q);
	assign suppress   = (uni_s3 != '0) && ({inter_s3, 16'd0} > prod_s3);
	assign out_take   = out_valid_q && res.ready;

	// edge mapping: remove pad, scale by inverse scale
	logic signed [19:0] t_val;
	logic [11:0]        pad_sel;
	logic [16:0]        c2_sel;
	logic [15:0]        sz_sel;
	always_comb begin
		pad_sel = edge_q[0] ? pad_top_q : pad_left_q;
		c2_sel  = edge_q[0] ? {cy_q, 1'b0} : {cx_q, 1'b0};
		sz_sel  = edge_q[0] ? h_q : w_q;
		if (edge_q[1])
			t_val = $signed({3'b0, c2_sel}) + $signed({4'b0, sz_sel})
				- $signed({3'b0, pad_sel, 5'b0});
		else
			t_val = $signed({3'b0, c2_sel}) - $signed({4'b0, sz_sel})
				- $signed({3'b0, pad_sel, 5'b0});
	end

	// rounding and clipping
	logic [38:0] rnd;
	logic [21:0] q_val;
	logic [15:0] lim_val, edge_val;
	always_comb begin
		rnd      = {1'b0, prod_s1} + 39'd65536;
		q_val    = rnd[38:17];
		lim_val  = edge_q[0] ? {img_h_q, 4'd0} : {img_w_q, 4'd0};
		if (!pos_s1)
			edge_val = '0;
		else if (q_val > {6'd0, lim_val})
			edge_val = lim_val;
		else
			edge_val = q_val[15:0];
	end

	// overlap rectangle of the current box and the kept box
	logic [15:0] ov_l, ov_t, ov_r, ov_b;
	always_comb begin
		ov_l = (keep_rd_q.c.box.l > cur_q.box.l) ? keep_rd_q.c.box.l : cur_q.box.l;
		ov_t = (keep_rd_q.c.box.t > cur_q.box.t) ? keep_rd_q.c.box.t : cur_q.box.t;
		ov_r = (keep_rd_q.c.box.r < cur_q.box.r) ? keep_rd_q.c.box.r : cur_q.box.r;
		ov_b = (keep_rd_q.c.box.b < cur_q.box.b) ? keep_rd_q.c.box.b : cur_q.box.b;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cand.valid) begin
					if (cand.score >= score_thr_q)
						state_d = ST_MUL;
					else if (cand.last_candidate)
						state_d = ST_NMS_INIT;
				end
			end
			ST_MUL:  state_d = ST_CLIP;
			ST_CLIP: state_d = (edge_q == 2'd3) ? ST_CHK : ST_MUL;
			ST_CHK: begin
				if (!degenerate)
					state_d = full ? ST_FULL_RD : ST_INS_RD;
				else
					state_d = last_q ? ST_NMS_INIT : ST_IDLE;
			end
			ST_FULL_RD:  state_d = ST_FULL_CMP;
			ST_FULL_CMP: begin
				if (beaten)
					state_d = ST_INS_RD;
				else
					state_d = last_q ? ST_NMS_INIT : ST_IDLE;
			end
			ST_INS_RD: begin
				if (ins_i_q == '0)
					state_d = last_q ? ST_NMS_INIT : ST_IDLE;
				else
					state_d = ST_INS_CMP;
			end
			ST_INS_CMP: begin
				if (beaten)
					state_d = ST_INS_RD;
				else
					state_d = last_q ? ST_NMS_INIT : ST_IDLE;
			end
			ST_NMS_INIT: state_d = ST_NMS_RD;
			ST_NMS_RD: begin
				if (nms_more)
					state_d = ST_NMS_AREA;
				else
					state_d = (kcnt_q == '0) ? ST_E_EMPTY : ST_E_RD;
			end
			ST_NMS_AREA: state_d = ST_K_RD;
			ST_K_RD:     state_d = kj_done ? ST_NMS_RD : ST_K0;
			ST_K0:       state_d = cls_match ? ST_K1 : ST_K_RD;
			ST_K1:       state_d = ST_K2;
			ST_K2:       state_d = ST_K3;
			ST_K3:       state_d = suppress ? ST_NMS_RD : ST_K_RD;
			ST_E_RD:     state_d = ST_E_LD;
			ST_E_LD:     state_d = ST_E_WAIT;
			ST_E_EMPTY:  state_d = ST_E_WAIT;
			ST_E_WAIT: begin
				if (out_take)
					state_d = out_last_q ? ST_IDLE : ST_E_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		st_re    = 1'b0;
		st_we    = 1'b0;
		kp_re    = 1'b0;
		kp_we    = 1'b0;
		st_raddr = '0;
		st_waddr = ins_i_q[CAND_AW-1:0];
		kp_raddr = kj_q[KEEP_AW-1:0];
		st_wdata = new_cand;
		unique case (state_q)
			ST_FULL_RD: begin
				st_re    = 1'b1;
				st_raddr = CAND_AW'(MAX_CAND - 1);
			end
			ST_INS_RD: begin
				if (ins_i_q == '0)
					st_we = 1'b1;
				else begin
					st_re    = 1'b1;
					st_raddr = CAND_AW'(ins_i_q - 1'b1);
				end
			end
			ST_INS_CMP: begin
				st_we = 1'b1;
				if (beaten)
					st_wdata = store_rd_q;
			end
			ST_NMS_RD: begin
				st_re    = nms_more;
				st_raddr = nms_i_q[CAND_AW-1:0];
			end
			ST_K_RD: begin
				kp_re = !kj_done;
				kp_we = kj_done;
			end
			ST_E_RD: kp_re = 1'b1;
			default: ;
		endcase
	end

	// memory arrays
	always_ff @(posedge clk) begin
		if (st_we)
			store_mem[st_waddr] <= st_wdata;
		if (st_re)
			store_rd_q <= store_mem[st_raddr];
	end

	always_ff @(posedge clk) begin
		if (kp_we)
			keep_mem[kcnt_q[KEEP_AW-1:0]] <= '{c: cur_q, area: area_q};
		if (kp_re)
			keep_rd_q <= keep_mem[kp_raddr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ins_i_q     <= '0;
			nms_i_q     <= '0;
			kcnt_q      <= '0;
			kj_q        <= '0;
			edge_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE:  edge_q <= '0;
				ST_CLIP:  edge_q <= edge_q + 2'd1;
				ST_CHK:   ins_i_q <= count_q;
				ST_FULL_CMP: begin
					if (beaten) begin
						count_q <= CAND_CW'(MAX_CAND - 1);
						ins_i_q <= CAND_CW'(MAX_CAND - 1);
					end
				end
				ST_INS_RD: begin
					if (ins_i_q == '0)
						count_q <= count_q + 1'b1;
				end
				ST_INS_CMP: begin
					if (beaten)
						ins_i_q <= ins_i_q - 1'b1;
					else
						count_q <= count_q + 1'b1;
				end
				ST_NMS_INIT: begin
					nms_i_q <= '0;
					kcnt_q  <= '0;
				end
				ST_NMS_RD: kj_q <= '0;
				ST_K_RD: begin
					if (kj_done) begin
						kcnt_q  <= kcnt_q + 1'b1;
						nms_i_q <= nms_i_q + 1'b1;
					end
				end
				ST_K0: begin
					if (!cls_match)
						kj_q <= kj_q + 1'b1;
				end
				ST_K3: begin
					if (suppress)
						nms_i_q <= nms_i_q + 1'b1;
					else
						kj_q <= kj_q + 1'b1;
				end
				ST_E_LD, ST_E_EMPTY: out_valid_q <= 1'b1;
				ST_E_WAIT: begin
					if (out_take) begin
						out_valid_q <= 1'b0;
						kj_q        <= kj_q + 1'b1;
						if (out_last_q)
							count_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cls_q   <= cand.class_index;
				score_q <= cand.score;
				cx_q    <= cand.ctr_x;
				cy_q    <= cand.ctr_y;
				w_q     <= cand.box_width;
				h_q     <= cand.box_height;
				last_q  <= cand.last_candidate;
			end
			ST_MUL: begin
				pos_s1  <= (t_val > 20'sd0);
				prod_s1 <= 38'(t_val[17:0]) * 38'(inv_scale_q);
			end
			ST_CLIP: edges_q[edge_q] <= edge_val;
			ST_NMS_AREA: begin
				cur_q  <= store_rd_q;
				area_q <= 32'(store_rd_q.box.r - store_rd_q.box.l)
					* 32'(store_rd_q.box.b - store_rd_q.box.t);
			end
			ST_K0: begin
				iw_s1    <= (ov_r > ov_l) ? (ov_r - ov_l) : '0;
				ih_s1    <= (ov_b > ov_t) ? (ov_b - ov_t) : '0;
				karea_s1 <= keep_rd_q.area;
			end
			ST_K1: begin
				inter_s2 <= 32'(iw_s1) * 32'(ih_s1);
				uni_s2   <= 33'(area_q) + 33'(karea_s1) - 33'(32'(iw_s1) * 32'(ih_s1));
			end
			ST_K2: begin
				inter_s3 <= inter_s2;
				uni_s3   <= uni_s2;
				prod_s3  <= 49'(ovl_thr_q) * 49'(uni_s2);
			end
			ST_E_LD: begin
				out_q      <= keep_rd_q;
				out_bv_q   <= 1'b1;
				out_last_q <= (kj_q == kcnt_q - 1'b1);
			end
			ST_E_EMPTY: begin
				out_q      <= '0;
				out_bv_q   <= 1'b0;
				out_last_q <= 1'b1;
			end
			default: ;
		endcase
	end

	// channel outputs
	assign cand.ready    = (state_q == ST_IDLE);
	assign res.valid     = out_valid_q;
	assign res.out_class = out_q.c.cls;
	assign res.out_score = out_q.c.score;
	assign res.left      = out_q.c.box.l;
	assign res.top       = out_q.c.box.t;
	assign res.right     = out_q.c.box.r;
	assign res.bottom    = out_q.c.box.b;
	assign res.box_valid = out_bv_q;
	assign res.last_box  = out_last_q;

endmodule
